>>> hw/rtl/pending_ack_table_with_timeout_core_macros.svh
// ---------------------------------------------------------------------------
// pending_ack_table_with_timeout_core_macros
// assertion helpers used by the core rtl file
// ---------------------------------------------------------------------------
`ifndef PENDING_ACK_TABLE_WITH_TIMEOUT_CORE_MACROS_SVH
`define PENDING_ACK_TABLE_WITH_TIMEOUT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PAT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pat assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PAT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pat assertion failed");

`endif

>>> hw/rtl/pat_pkg.sv
// ---------------------------------------------------------------------------
// pat_pkg
// shared types, codes and helpers of the pending ack table
// ---------------------------------------------------------------------------
`default_nettype none

package pat_pkg;

    localparam int ID_W    = 16;
    localparam int TMO_W   = 16;
    localparam int STAT_W  = 32;
    localparam int SUM_W   = 48;
    localparam int KIND_W  = 4;
    localparam int OP_W    = 3;
    localparam int PEND_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TMO_W-1:0] DEFAULT_TIMEOUT_RST = 16'd5000;
    localparam logic [TMO_W-1:0] CHECK_INTERVAL_RST  = 16'd500;

    // opcodes
    localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
    localparam logic [OP_W-1:0] OP_RESPONSE = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_REGISTERED  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_REJ_INVALID = 4'd1;
    localparam logic [KIND_W-1:0] KIND_REJ_FULL    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_MATCHED     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_CANCELLED   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_CANCEL_MISS = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CLEARED     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_EXPIRED     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE   = 4'd9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKER_ENABLE  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [STAT_W-1:0] created;
        logic [TMO_W-1:0]  tmo;
        logic              notify;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_APPLY,
        S_SCAN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT_RD,
        S_OUT_SHOW,
        S_OUT_FINAL
    } state_t;

    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
        sat_inc = (v == {STAT_W{1'b1}}) ? v : v + STAT_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pat_if.sv
// ---------------------------------------------------------------------------
// pat_if
// channel interfaces: request input, result output, configuration write
// ---------------------------------------------------------------------------
`default_nettype none

interface pat_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] ack_id;
    logic [15:0] timeout_ms;
    logic        notify_timeout;
    modport source (output valid, opcode, ack_id, timeout_ms, notify_timeout, input ready);
    modport sink   (input valid, opcode, ack_id, timeout_ms, notify_timeout, output ready);
endinterface

interface pat_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [15:0] result_id;
    logic [31:0] response_time_ms;
    logic        last;
    logic [5:0]  pending_count;
    logic [31:0] accepted_count;
    logic [31:0] matched_count;
    logic [31:0] expired_count;
    logic [31:0] average_response_ms;
    modport source (output valid, kind, result_id, response_time_ms, last, pending_count,
                    accepted_count, matched_count, expired_count,
                    average_response_ms, input ready);
    modport sink   (input valid, kind, result_id, response_time_ms, last, pending_count,
                    accepted_count, matched_count, expired_count,
                    average_response_ms, output ready);
endinterface

interface pat_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pat_ram.sv
// ---------------------------------------------------------------------------
// pat_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module pat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

>>> hw/rtl/pat_div.sv
// ---------------------------------------------------------------------------
// pat_div
// restoring divider, one quotient bit per cycle, saturated 32-bit quotient
// ---------------------------------------------------------------------------
`default_nettype none

module pat_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [pat_pkg::SUM_W-1:0]  dividend,
    input  wire logic [pat_pkg::STAT_W-1:0] divisor,
    output logic                           done,
    output logic      [pat_pkg::STAT_W-1:0] quotient
);
    import pat_pkg::*;

    logic [STAT_W:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [STAT_W-1:0] dvs_reg, dvs_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STAT_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg[STAT_W-1:0], quo_reg[SUM_W-1]};
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = 6'(SUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = (dvs_reg == '0) ? '0 :
                      (|quo_reg[SUM_W-1:STAT_W]) ? {STAT_W{1'b1}} : quo_reg[STAT_W-1:0];
endmodule

`default_nettype wire

>>> hw/rtl/pending_ack_table_with_timeout_core.sv
// ---------------------------------------------------------------------------
// pending_ack_table_with_timeout_core
// table of outstanding requests keyed by id, with tick-driven expiry scans
// ---------------------------------------------------------------------------
//
//  channel  | role | handshake     | payload
//  ---------+------+---------------+--------------------------------------------
//  in_ch    | sink | valid / ready | opcode, ack_id, timeout_ms, notify_timeout
//  out_ch   | src  | valid / ready | kind, result_id, response_time_ms, last, stats
//  cfg      | sink | valid / ready | index, data (ready always high)
//
//  one input transaction at a time; ready is high only while idle
//  path to the first result: clear and plain tick go straight to the final result,
//    tick with scan walks the entry ram, register, response and cancel walk the
//    entry ram then apply, and a matched response also runs the divider
//  expiry results precede the final one; valid bits are flops cleared at reset
//  results hold on the output while out_ch.ready is low
// ---------------------------------------------------------------------------
`default_nettype none

`include "pending_ack_table_with_timeout_core_macros.svh"

module pending_ack_table_with_timeout_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pat_in_if.sink    in_ch,
    pat_out_if.source out_ch,
    pat_cfg_if.sink   cfg
);
    import pat_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] DEPTH_CNT = IW'(TABLE_DEPTH);

    // configuration
    logic [TMO_W-1:0] default_timeout_reg;
    logic [TMO_W-1:0] check_interval_reg;
    logic             checker_enable_reg;

    // control
    state_t state_reg, state_next;

    // latched request
    logic [OP_W-1:0]  op_reg, op_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [TMO_W-1:0] tmo_reg, tmo_next;
    logic             nt_reg, nt_next;

    // persistent state
    logic [STAT_W-1:0]      now_reg, now_next;
    logic [TMO_W-1:0]       cd_reg, cd_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [IW-1:0]          pend_reg, pend_next;
    logic [STAT_W-1:0]      total_reg, total_next;
    logic [STAT_W-1:0]      success_reg, success_next;
    logic [STAT_W-1:0]      expired_reg, expired_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [STAT_W-1:0]      avg_reg, avg_next;

    // walk and result bookkeeping
    logic [IW-1:0]     idx_reg, idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              found_reg, found_next;
    logic [AW-1:0]     found_slot_reg, found_slot_next;
    logic [STAT_W-1:0] found_created_reg, found_created_next;
    logic              free_found_reg, free_found_next;
    logic [AW-1:0]     free_slot_reg, free_slot_next;
    logic [IW-1:0]     wcnt_reg, wcnt_next;
    logic [IW-1:0]     rcnt_reg, rcnt_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    logic [STAT_W-1:0] rt_reg, rt_next;

    // memories
    entry_t        ent_wdata, ent_rdata;
    logic          ent_we;
    logic [AW-1:0] ent_waddr;
    logic          buf_we;
    logic [ID_W-1:0] buf_rdata;

    // divider
    logic              div_start;
    logic              div_done;
    logic [STAT_W-1:0] div_quo;

    // misc
    logic              in_fire, out_fire;
    logic              walk_done;
    logic [TMO_W-1:0]  cd_inc;
    logic              tick_scan;
    logic [STAT_W-1:0] elapsed_cmp;
    logic [STAT_W-1:0] elapsed_rsp;
    logic [SUM_W:0]    sum_add;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign out_fire  = out_ch.valid && out_ch.ready;
    assign walk_done = (idx_reg == DEPTH_CNT) && !cmp_valid_reg;
    assign cd_inc    = cd_reg + TMO_W'(1);
    assign tick_scan = checker_enable_reg && (cd_inc >= check_interval_reg);
    // age of the entry under compare, and of the matched entry
    assign elapsed_cmp = now_reg - ent_rdata.created;
    assign elapsed_rsp = now_reg - found_created_reg;
    assign sum_add     = {1'b0, sum_reg} + {{(SUM_W-STAT_W+1){1'b0}}, elapsed_rsp};

    pat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ent_rdata)
    );

    // ids of expired entries that asked for notification, in slot order
    pat_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_DEPTH)
    ) u_expiry_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (wcnt_reg[AW-1:0]),
        .wdata (ent_rdata.id),
        .raddr (rcnt_reg[AW-1:0]),
        .rdata (buf_rdata)
    );

    pat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (success_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (in_ch.opcode == OP_REGISTER || in_ch.opcode == OP_RESPONSE ||
                                 in_ch.opcode == OP_CANCEL)
                        state_next = S_LOOKUP;
                    else if (in_ch.opcode == OP_CLEAR)
                        state_next = S_OUT_FINAL;
                    else if (in_ch.opcode == OP_TICK)
                        state_next = tick_scan ? S_SCAN : S_OUT_FINAL;
                    else
                        state_next = S_IDLE;
                end
            end
            S_LOOKUP:
            begin
                if (walk_done)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = (op_reg == OP_RESPONSE && found_reg) ? S_DIV_GO : S_OUT_FINAL;
            end
            S_SCAN:
            begin
                if (walk_done)
                    state_next = (wcnt_reg != '0) ? S_OUT_RD : S_OUT_FINAL;
            end
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_done)
                    state_next = S_OUT_FINAL;
            end
            S_OUT_RD:   state_next = S_OUT_SHOW;
            S_OUT_SHOW:
            begin
                if (out_fire)
                    state_next = (rcnt_reg + IW'(1) == wcnt_reg) ? S_OUT_FINAL : S_OUT_RD;
            end
            S_OUT_FINAL:
            begin
                if (out_fire)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // handshake and unit controls
    always_comb
    begin
        in_ch.ready  = (state_reg == S_IDLE);
        out_ch.valid = (state_reg == S_OUT_SHOW) || (state_reg == S_OUT_FINAL);
        div_start    = (state_reg == S_DIV_GO);
        cfg.ready    = 1'b1;
    end

    // datapath
    always_comb
    begin
        op_next            = op_reg;
        id_next            = id_reg;
        tmo_next           = tmo_reg;
        nt_next            = nt_reg;
        now_next           = now_reg;
        cd_next            = cd_reg;
        valid_next         = valid_reg;
        pend_next          = pend_reg;
        total_next         = total_reg;
        success_next       = success_reg;
        expired_next       = expired_reg;
        sum_next           = sum_reg;
        avg_next           = avg_reg;
        idx_next           = idx_reg;
        cmp_valid_next     = 1'b0;
        cmp_idx_next       = idx_reg[AW-1:0];
        found_next         = found_reg;
        found_slot_next    = found_slot_reg;
        found_created_next = found_created_reg;
        free_found_next    = free_found_reg;
        free_slot_next     = free_slot_reg;
        wcnt_next          = wcnt_reg;
        rcnt_next          = rcnt_reg;
        kind_next          = kind_reg;
        rid_next           = rid_reg;
        rt_next            = rt_reg;
        ent_we             = 1'b0;
        ent_waddr          = free_slot_reg;
        ent_wdata.id       = id_reg;
        ent_wdata.created  = now_reg;
        ent_wdata.tmo      = (tmo_reg != '0) ? tmo_reg : default_timeout_reg;
        ent_wdata.notify   = nt_reg;
        buf_we             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next        = '0;
                found_next      = 1'b0;
                free_found_next = 1'b0;
                wcnt_next       = '0;
                rcnt_next       = '0;
                rid_next        = '0;
                rt_next         = '0;
                if (in_fire)
                begin
                    op_next  = in_ch.opcode;
                    id_next  = in_ch.ack_id;
                    tmo_next = in_ch.timeout_ms;
                    nt_next  = in_ch.notify_timeout;
                    if (in_ch.opcode == OP_CLEAR)
                    begin
                        valid_next = '0;
                        pend_next  = '0;
                        kind_next  = KIND_CLEARED;
                    end
                    if (in_ch.opcode == OP_TICK)
                    begin
                        now_next  = now_reg + STAT_W'(1);
                        kind_next = KIND_TICK_DONE;
                        if (checker_enable_reg)
                            cd_next = tick_scan ? '0 : cd_inc;
                    end
                end
            end
            S_LOOKUP, S_SCAN:
            begin
                // read one slot per cycle, compare it in the next cycle
                if (idx_reg != DEPTH_CNT)
                begin
                    idx_next       = idx_reg + IW'(1);
                    cmp_valid_next = 1'b1;
                end
                if (cmp_valid_reg && state_reg == S_LOOKUP)
                begin
                    if (valid_reg[cmp_idx_reg] && ent_rdata.id == id_reg)
                    begin
                        found_next         = 1'b1;
                        found_slot_next    = cmp_idx_reg;
                        found_created_next = ent_rdata.created;
                    end
                    if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = cmp_idx_reg;
                    end
                end
                if (cmp_valid_reg && state_reg == S_SCAN && valid_reg[cmp_idx_reg] &&
                    elapsed_cmp >= {{(STAT_W-TMO_W){1'b0}}, ent_rdata.tmo})
                begin
                    valid_next[cmp_idx_reg] = 1'b0;
                    pend_next               = pend_reg - IW'(1);
                    expired_next            = sat_inc(expired_reg);
                    if (ent_rdata.notify)
                    begin
                        buf_we    = 1'b1;
                        wcnt_next = wcnt_reg + IW'(1);
                    end
                end
            end
            S_APPLY:
            begin
                rid_next = id_reg;
                rt_next  = '0;
                priority case (op_reg)
                    OP_REGISTER:
                    begin
                        priority if (id_reg == '0 || found_reg)
                            kind_next = KIND_REJ_INVALID;
                        else if (!free_found_reg)
                            kind_next = KIND_REJ_FULL;
                        else
                        begin
                            ent_we                    = 1'b1;
                            valid_next[free_slot_reg] = 1'b1;
                            pend_next                 = pend_reg + IW'(1);
                            total_next                = sat_inc(total_reg);
                            kind_next                 = KIND_REGISTERED;
                        end
                    end
                    OP_RESPONSE:
                    begin
                        if (found_reg)
                        begin
                            valid_next[found_slot_reg] = 1'b0;
                            pend_next                  = pend_reg - IW'(1);
                            success_next               = sat_inc(success_reg);
                            sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
                            rt_next                    = elapsed_rsp;
                            kind_next                  = KIND_MATCHED;
                        end
                        else
                            kind_next = KIND_UNKNOWN;
                    end
                    default:
                    begin
                        if (found_reg)
                        begin
                            valid_next[found_slot_reg] = 1'b0;
                            pend_next                  = pend_reg - IW'(1);
                            kind_next                  = KIND_CANCELLED;
                        end
                        else
                            kind_next = KIND_CANCEL_MISS;
                    end
                endcase
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                    avg_next = div_quo;
            end
            S_OUT_SHOW:
            begin
                if (out_fire)
                    rcnt_next = rcnt_reg + IW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            default_timeout_reg <= DEFAULT_TIMEOUT_RST;
            check_interval_reg  <= CHECK_INTERVAL_RST;
            checker_enable_reg  <= 1'b1;
            now_reg             <= '0;
            cd_reg              <= '0;
            valid_reg           <= '0;
            pend_reg            <= '0;
            total_reg           <= '0;
            success_reg         <= '0;
            expired_reg         <= '0;
            sum_reg             <= '0;
            avg_reg             <= '0;
            idx_reg             <= '0;
            cmp_valid_reg       <= 1'b0;
            found_reg           <= 1'b0;
            free_found_reg      <= 1'b0;
            wcnt_reg            <= '0;
            rcnt_reg            <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            cd_reg         <= cd_next;
            valid_reg      <= valid_next;
            pend_reg       <= pend_next;
            total_reg      <= total_next;
            success_reg    <= success_next;
            expired_reg    <= expired_next;
            sum_reg        <= sum_next;
            avg_reg        <= avg_next;
            idx_reg        <= idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            wcnt_reg       <= wcnt_next;
            rcnt_reg       <= rcnt_next;
            // configuration write transaction
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_DEFAULT_TIMEOUT: default_timeout_reg <= cfg.data;
                    CFG_CHECK_INTERVAL:  check_interval_reg  <= cfg.data;
                    CFG_CHECKER_ENABLE:  checker_enable_reg  <= cfg.data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        id_reg            <= id_next;
        tmo_reg           <= tmo_next;
        nt_reg            <= nt_next;
        cmp_idx_reg       <= cmp_idx_next;
        found_slot_reg    <= found_slot_next;
        found_created_reg <= found_created_next;
        free_slot_reg     <= free_slot_next;
        kind_reg          <= kind_next;
        rid_reg           <= rid_next;
        rt_reg            <= rt_next;
    end

    // result payload: expired entries come from the buffer, the final one from registers
    assign out_ch.kind                = (state_reg == S_OUT_SHOW) ? KIND_EXPIRED : kind_reg;
    assign out_ch.result_id           = (state_reg == S_OUT_SHOW) ? buf_rdata : rid_reg;
    assign out_ch.response_time_ms    = (state_reg == S_OUT_SHOW) ? '0 : rt_reg;
    assign out_ch.last                = (state_reg == S_OUT_FINAL);
    assign out_ch.pending_count       = PEND_W'(pend_reg);
    assign out_ch.accepted_count      = total_reg;
    assign out_ch.matched_count       = success_reg;
    assign out_ch.expired_count       = expired_reg;
    assign out_ch.average_response_ms = avg_reg;

    // pending count tracks the valid bits
    `PAT_ASSERT_IMPL(a_pend_matches_valid, 1'b1, $countones(valid_reg) == pend_reg)
    // no new request while a result is still offered
    `PAT_ASSERT_IMPL(a_no_overlap, in_ch.ready, !out_ch.valid)
    // an expiry result always has a buffered id behind it
    `PAT_ASSERT_IMPL(a_buf_in_range, state_reg == S_OUT_SHOW, rcnt_reg < wcnt_reg)
    // after a non-final result, another result follows
    `PAT_ASSERT_NEXT(a_more_follows, out_fire && !out_ch.last,
                     state_reg == S_OUT_RD || state_reg == S_OUT_FINAL)
endmodule

`default_nettype wire
